FILE: hdl/stkm_pkg.sv
// ----------------------------------------------------------------------------
// stkm_pkg
// shared constants, opcodes and types of the stack machine execute unit
// ----------------------------------------------------------------------------
package stkm_pkg;

	localparam int STACK_DEPTH  = 32;
	localparam int ARG_DEPTH    = 32;
	localparam int LOCAL_DEPTH  = 32;
	localparam int STATIC_DEPTH = 32;
	localparam int HEAP_DEPTH   = 128;
	localparam int CALL_DEPTH   = 64;

	localparam int SW  = $clog2(STACK_DEPTH);
	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(ARG_DEPTH);
	localparam int ABW = $clog2(ARG_DEPTH + 1);
	localparam int LW  = $clog2(LOCAL_DEPTH);
	localparam int LBW = $clog2(LOCAL_DEPTH + 1);
	localparam int TW  = $clog2(STATIC_DEPTH);
	localparam int HW  = $clog2(HEAP_DEPTH);
	localparam int HUW = $clog2(HEAP_DEPTH + 1);
	localparam int HSW = $clog2(CALL_DEPTH);
	localparam int HCW = $clog2(CALL_DEPTH + 1);

	localparam logic [4:0] F_END    = 5'd0;
	localparam logic [4:0] F_ADD    = 5'd1;
	localparam logic [4:0] F_SUB    = 5'd2;
	localparam logic [4:0] F_MULT   = 5'd3;
	localparam logic [4:0] F_DIV    = 5'd4;
	localparam logic [4:0] F_EQ     = 5'd5;
	localparam logic [4:0] F_UNEQ   = 5'd6;
	localparam logic [4:0] F_GT_EQ  = 5'd7;
	localparam logic [4:0] F_LT_EQ  = 5'd8;
	localparam logic [4:0] F_GT     = 5'd9;
	localparam logic [4:0] F_LT     = 5'd10;
	localparam logic [4:0] F_GOTO   = 5'd11;
	localparam logic [4:0] F_IFGOTO = 5'd12;
	localparam logic [4:0] F_PUSH   = 5'd13;
	localparam logic [4:0] F_POP    = 5'd14;
	localparam logic [4:0] F_PRINTC = 5'd15;
	localparam logic [4:0] F_NOT    = 5'd16;
	localparam logic [4:0] F_PRINTN = 5'd17;
	localparam logic [4:0] F_BACK   = 5'd18;
	localparam logic [4:0] F_CALL   = 5'd19;

	localparam logic [2:0] SEG_ARG     = 3'd0;
	localparam logic [2:0] SEG_LOCAL   = 3'd1;
	localparam logic [2:0] SEG_STATIC  = 3'd2;
	localparam logic [2:0] SEG_HEAP    = 3'd3;
	localparam logic [2:0] SEG_CONST   = 3'd4;
	localparam logic [2:0] SEG_HEAPPOS = 3'd5;
	localparam logic [2:0] SEG_POINTER = 3'd6;
	localparam logic [2:0] SEG_HEAPARR = 3'd7;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_UNDER = 3'd1;
	localparam logic [2:0] ERR_OVER  = 3'd2;
	localparam logic [2:0] ERR_SEG   = 3'd3;
	localparam logic [2:0] ERR_RANGE = 3'd4;
	localparam logic [2:0] ERR_DIVZ  = 3'd5;
	localparam logic [2:0] ERR_CALL  = 3'd6;

	localparam logic [1:0] PK_NONE = 2'd0;
	localparam logic [1:0] PK_CHAR = 2'd1;
	localparam logic [1:0] PK_NUM  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

FILE: hdl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// executes one decoded stack-machine instruction per input word
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | func 5, segment 3, operand 32, pc 16        | -
//  m_axis   | out | next_pc 16, print_value 32, halted 1, err 3 | print_kind 2
//
//  an instruction goes through accept, memory read, then execute and write back
//  div also passes through the radix-2 divider
//  the next word is accepted while a result still waits on m_axis
//  execute stalls while the output register is full and not taken
//  reset clears all counters; store entries read as zero until written
// ----------------------------------------------------------------------------
module stack_machine_execute_unit import stkm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // func, segment, operand, pc
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // next_pc, print_value, halted, error, zero pad
	output logic [1:0]  m_axis_tuser   // print_kind
);

	function automatic logic [33:0] idx_sum(logic [15:0] base, logic [31:0] off);
		return {18'd0, base} + {{2{off[31]}}, off};
	endfunction

	function automatic logic idx_ok(logic [33:0] sum, logic [15:0] depth);
		return !sum[33] && (sum[32:0] < {17'd0, depth});
	endfunction

	state_t state_q, state_n;

	logic [4:0]  func_q;
	logic [2:0]  seg_q;
	logic [31:0] op_q;
	logic [15:0] pc_q;

	logic [CW-1:0]  cnt_q;
	logic [ABW-1:0] arg_base_q, arg_next_q;
	logic [LBW-1:0] local_base_q, local_next_q;
	logic [HUW-1:0] heap_used_q, heap_base_q;
	logic [HCW-1:0] ahc_q, lhc_q;
	logic           pend_q, stopped_q, dq_vld_q;

	logic [31:0] stk_mem [STACK_DEPTH];
	logic [31:0] arg_mem [ARG_DEPTH];
	logic [31:0] loc_mem [LOCAL_DEPTH];
	logic [31:0] sta_mem [STATIC_DEPTH];
	logic [31:0] hp_mem  [HEAP_DEPTH];
	logic [ABW-1:0] sab_mem [CALL_DEPTH];
	logic [LBW-1:0] slb_mem [CALL_DEPTH];

	logic [ARG_DEPTH-1:0]    arg_vld_q;
	logic [LOCAL_DEPTH-1:0]  loc_vld_q;
	logic [STATIC_DEPTH-1:0] sta_vld_q;
	logic [HEAP_DEPTH-1:0]   hp_vld_q;

	logic [31:0]    s1_q, s2_q, arg_rd_q, loc_rd_q, sta_rd_q, hp_rd_q;
	logic           arg_rv_q, loc_rv_q, sta_rv_q, hp_rv_q;
	logic [ABW-1:0] sab_q;
	logic [LBW-1:0] slb_q;

	logic        out_valid_q;
	logic [15:0] out_next_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_pval_q;
	logic        out_halt_q;
	logic [2:0]  out_err_q;

	logic accept, rd_en, commit, slot_free, need_div, div_go;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// index arithmetic
	logic [ABW-1:0] arg_nb;
	logic [33:0]    arg_rsum, arg_wsum, loc_sum, sta_sum, hp_sum;
	logic           arg_rok, arg_wok, loc_ok, sta_ok, hp_ok;

	assign arg_nb   = (pend_q) ? arg_next_q : arg_base_q;
	assign arg_rsum = idx_sum(16'(arg_base_q), op_q);
	assign arg_wsum = idx_sum(16'(arg_nb), op_q);
	assign loc_sum  = idx_sum(16'(local_base_q), op_q);
	assign sta_sum  = idx_sum(16'd0, op_q);
	assign hp_sum   = idx_sum(16'(heap_base_q), op_q);
	assign arg_rok  = idx_ok(arg_rsum, 16'(ARG_DEPTH));
	assign arg_wok  = idx_ok(arg_wsum, 16'(ARG_DEPTH));
	assign loc_ok   = idx_ok(loc_sum, 16'(LOCAL_DEPTH));
	assign sta_ok   = idx_ok(sta_sum, 16'(STATIC_DEPTH));
	assign hp_ok    = idx_ok(hp_sum, 16'(HEAP_DEPTH));

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign slot_free = !out_valid_q || m_axis_tready;

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_axis_tdata[4:0];
			seg_q  <= s_axis_tdata[7:5];
			op_q   <= s_axis_tdata[39:8];
			pc_q   <= s_axis_tdata[55:40];
		end
	end

	// synchronous reads; writes only happen in execute, so no overlap with a read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			s1_q     <= stk_mem[SW'(cnt_q - CW'(1))];
			s2_q     <= stk_mem[SW'(cnt_q - CW'(2))];
			arg_rd_q <= arg_mem[arg_rsum[AW-1:0]];
			loc_rd_q <= loc_mem[loc_sum[LW-1:0]];
			sta_rd_q <= sta_mem[sta_sum[TW-1:0]];
			hp_rd_q  <= hp_mem[hp_sum[HW-1:0]];
			sab_q    <= sab_mem[HSW'(ahc_q - HCW'(1))];
			slb_q    <= slb_mem[HSW'(lhc_q - HCW'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_rv_q <= 1'b0;
			loc_rv_q <= 1'b0;
			sta_rv_q <= 1'b0;
			hp_rv_q  <= 1'b0;
		end else if (rd_en) begin
			arg_rv_q <= arg_vld_q[arg_rsum[AW-1:0]];
			loc_rv_q <= loc_vld_q[loc_sum[LW-1:0]];
			sta_rv_q <= sta_vld_q[sta_sum[TW-1:0]];
			hp_rv_q  <= hp_vld_q[hp_sum[HW-1:0]];
		end
	end

	// execute
	logic [31:0]    s1s_r, alu_r, push_v;
	logic [2:0]     err;
	logic [15:0]    nxt;
	logic [1:0]     kind;
	logic [31:0]    pval;
	logic           stk_we;
	logic [SW-1:0]  stk_wa;
	logic [31:0]    stk_wd;
	logic [CW-1:0]  cnt_n;
	logic           arg_we, loc_we, sta_we, hp_we, sab_we, slb_we;
	logic [HW-1:0]  hp_wa;
	logic [31:0]    hp_wd;
	logic [ABW-1:0] arg_base_n, arg_next_n;
	logic [LBW-1:0] local_base_n, local_next_n;
	logic [HUW-1:0] heap_used_n, heap_base_n;
	logic [HCW-1:0] ahc_n, lhc_n;
	logic           pend_n, stop_n, upd;

	assign s1s_r = 32'd0 - s1_q;

	always_comb begin
		case (func_q)
			F_ADD:   alu_r = s2_q + s1_q;
			F_SUB:   alu_r = s2_q - s1_q;
			F_MULT:  alu_r = s2_q * s1_q;
			F_DIV:   alu_r = div_rsp.quotient;
			F_EQ:    alu_r = {31'd0, s2_q == s1_q};
			F_UNEQ:  alu_r = {31'd0, s2_q != s1_q};
			F_GT_EQ: alu_r = {31'd0, $signed(s2_q) >= $signed(s1_q)};
			F_LT_EQ: alu_r = {31'd0, $signed(s2_q) <= $signed(s1_q)};
			F_GT:    alu_r = {31'd0, $signed(s2_q) > $signed(s1_q)};
			default: alu_r = {31'd0, $signed(s2_q) < $signed(s1_q)};
		endcase
	end

	always_comb begin
		case (seg_q)
			SEG_ARG:    push_v = arg_rv_q ? arg_rd_q : 32'd0;
			SEG_LOCAL:  push_v = loc_rv_q ? loc_rd_q : 32'd0;
			SEG_STATIC: push_v = sta_rv_q ? sta_rd_q : 32'd0;
			SEG_HEAP:   push_v = hp_rv_q ? hp_rd_q : 32'd0;
			SEG_CONST:  push_v = op_q;
			default:    push_v = 32'(heap_used_q);
		endcase
	end

	assign need_div = !stopped_q && func_q == F_DIV && cnt_q >= CW'(2) && s1_q != 32'd0;

	always_comb begin
		err          = ERR_NONE;
		nxt          = pc_q + 16'd1;
		kind         = PK_NONE;
		pval         = 32'd0;
		stk_we       = 1'b0;
		stk_wa       = SW'(cnt_q);
		stk_wd       = push_v;
		cnt_n        = cnt_q;
		arg_we       = 1'b0;
		loc_we       = 1'b0;
		sta_we       = 1'b0;
		hp_we        = 1'b0;
		hp_wa        = hp_sum[HW-1:0];
		hp_wd        = s1_q;
		sab_we       = 1'b0;
		slb_we       = 1'b0;
		arg_base_n   = arg_base_q;
		arg_next_n   = arg_next_q;
		local_base_n = local_base_q;
		local_next_n = local_next_q;
		heap_used_n  = heap_used_q;
		heap_base_n  = heap_base_q;
		ahc_n        = ahc_q;
		lhc_n        = lhc_q;
		pend_n       = pend_q;
		stop_n       = stopped_q;
		case (func_q)
			F_END: begin
				stop_n = 1'b1;
				nxt    = pc_q;
			end
			F_ADD, F_SUB, F_MULT, F_DIV, F_EQ, F_UNEQ, F_GT_EQ, F_LT_EQ, F_GT, F_LT: begin
				if (cnt_q == CW'(1) && func_q == F_SUB) begin
					// negate the only entry in place
					stk_we = 1'b1;
					stk_wa = '0;
					stk_wd = s1s_r;
				end else if (cnt_q < CW'(2)) begin
					err = ERR_UNDER;
				end else if (func_q == F_DIV && s1_q == 32'd0) begin
					err = ERR_DIVZ;
				end else begin
					stk_we = 1'b1;
					stk_wa = SW'(cnt_q - CW'(2));
					stk_wd = alu_r;
					cnt_n  = cnt_q - CW'(1);
				end
			end
			F_GOTO: nxt = op_q[15:0];
			F_IFGOTO: begin
				if (cnt_q == '0) begin
					err = ERR_UNDER;
				end else begin
					cnt_n = cnt_q - CW'(1);
					if (s1_q != 32'd0) nxt = op_q[15:0];
				end
			end
			F_PUSH: begin
				if (seg_q == SEG_POINTER || seg_q == SEG_HEAPARR) err = ERR_SEG;
				else if (cnt_q >= CW'(STACK_DEPTH)) err = ERR_OVER;
				else if (seg_q == SEG_ARG && !arg_rok) err = ERR_RANGE;
				else if (seg_q == SEG_LOCAL && !loc_ok) err = ERR_RANGE;
				else if (seg_q == SEG_STATIC && !sta_ok) err = ERR_RANGE;
				else if (seg_q == SEG_HEAP && !hp_ok) err = ERR_RANGE;
				else begin
					stk_we = 1'b1;
					cnt_n  = cnt_q + CW'(1);
				end
			end
			F_POP: begin
				if (seg_q == SEG_CONST || seg_q == SEG_HEAPPOS) begin
					err = ERR_SEG;
				end else if (seg_q == SEG_HEAPARR) begin
					if (heap_used_q >= HUW'(HEAP_DEPTH)) begin
						err = ERR_RANGE;
					end else begin
						hp_we       = 1'b1;
						hp_wa       = HW'(heap_used_q);
						hp_wd       = 32'd0;
						heap_used_n = heap_used_q + HUW'(1);
					end
				end else if (cnt_q == '0) begin
					err = ERR_UNDER;
				end else begin
					case (seg_q)
						SEG_ARG: begin
							if (pend_q && ahc_q >= HCW'(CALL_DEPTH)) err = ERR_CALL;
							else if (!arg_wok) err = ERR_RANGE;
							else begin
								if (pend_q) begin
									// first pop after a call opens the new argument frame
									sab_we     = 1'b1;
									ahc_n      = ahc_q + HCW'(1);
									arg_base_n = arg_nb;
									pend_n     = 1'b0;
								end
								arg_we = 1'b1;
								if (arg_next_q < ABW'(ARG_DEPTH)) arg_next_n = arg_next_q + ABW'(1);
							end
						end
						SEG_LOCAL: begin
							if (!loc_ok) err = ERR_RANGE;
							else begin
								loc_we = 1'b1;
								if (local_next_q < LBW'(LOCAL_DEPTH))
									local_next_n = local_next_q + LBW'(1);
							end
						end
						SEG_STATIC: begin
							if (!sta_ok) err = ERR_RANGE;
							else sta_we = 1'b1;
						end
						SEG_HEAP: begin
							if (!hp_ok) err = ERR_RANGE;
							else hp_we = 1'b1;
						end
						default: begin
							if (s1_q[31] || s1_q[30:0] > 31'(heap_used_q)) err = ERR_RANGE;
							else heap_base_n = HUW'(s1_q);
						end
					endcase
					cnt_n = cnt_q - CW'(1);
				end
			end
			F_PRINTC, F_PRINTN: begin
				if (cnt_q == '0) begin
					err = ERR_UNDER;
				end else begin
					cnt_n = cnt_q - CW'(1);
					pval  = s1_q;
					kind  = (func_q == F_PRINTC) ? PK_CHAR : PK_NUM;
				end
			end
			F_NOT: begin
				if (cnt_q == '0) begin
					err = ERR_UNDER;
				end else begin
					stk_we = 1'b1;
					stk_wa = SW'(cnt_q - CW'(1));
					stk_wd = {31'd0, s1_q == 32'd0};
				end
			end
			F_BACK: begin
				if (cnt_q == '0) err = ERR_UNDER;
				else if (ahc_q == '0 || lhc_q == '0) err = ERR_CALL;
				else begin
					nxt          = s1_q[15:0];
					cnt_n        = cnt_q - CW'(1);
					arg_next_n   = arg_base_q;
					arg_base_n   = sab_q;
					ahc_n        = ahc_q - HCW'(1);
					local_next_n = local_base_q;
					local_base_n = slb_q;
					lhc_n        = lhc_q - HCW'(1);
				end
			end
			F_CALL: begin
				if (cnt_q >= CW'(STACK_DEPTH)) err = ERR_OVER;
				else if (lhc_q >= HCW'(CALL_DEPTH)) err = ERR_CALL;
				else begin
					stk_we       = 1'b1;
					stk_wd       = {16'd0, pc_q + 16'd1};
					cnt_n        = cnt_q + CW'(1);
					nxt          = op_q[15:0];
					pend_n       = 1'b1;
					slb_we       = 1'b1;
					lhc_n        = lhc_q + HCW'(1);
					local_base_n = local_next_q;
				end
			end
			default: ;
		endcase
		if (stopped_q) begin
			err  = ERR_NONE;
			nxt  = pc_q;
			kind = PK_NONE;
			pval = 32'd0;
		end else if (err != ERR_NONE) begin
			stop_n = 1'b1;
			nxt    = pc_q;
			kind   = PK_NONE;
			pval   = 32'd0;
		end
	end

	// stack and frame state change only on a clean commit of a running machine; the halt flag on any commit
	assign upd = commit && !stopped_q && err == ERR_NONE;

	always_ff @(posedge clk) begin
		if (upd && stk_we) stk_mem[stk_wa] <= stk_wd;
		if (upd && arg_we) arg_mem[arg_wsum[AW-1:0]] <= s1_q;
		if (upd && loc_we) loc_mem[loc_sum[LW-1:0]] <= s1_q;
		if (upd && sta_we) sta_mem[sta_sum[TW-1:0]] <= s1_q;
		if (upd && hp_we) hp_mem[hp_wa] <= hp_wd;
		if (upd && sab_we) sab_mem[HSW'(ahc_q)] <= arg_base_q;
		if (upd && slb_we) slb_mem[HSW'(lhc_q)] <= local_base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_vld_q    <= '0;
			loc_vld_q    <= '0;
			sta_vld_q    <= '0;
			hp_vld_q     <= '0;
			cnt_q        <= '0;
			arg_base_q   <= '0;
			arg_next_q   <= '0;
			local_base_q <= '0;
			local_next_q <= '0;
			heap_used_q  <= '0;
			heap_base_q  <= '0;
			ahc_q        <= '0;
			lhc_q        <= '0;
			pend_q       <= 1'b0;
			stopped_q    <= 1'b0;
		end else begin
			if (upd) begin
				if (arg_we) arg_vld_q[arg_wsum[AW-1:0]] <= 1'b1;
				if (loc_we) loc_vld_q[loc_sum[LW-1:0]] <= 1'b1;
				if (sta_we) sta_vld_q[sta_sum[TW-1:0]] <= 1'b1;
				if (hp_we) hp_vld_q[hp_wa] <= 1'b1;
				cnt_q        <= cnt_n;
				arg_base_q   <= arg_base_n;
				arg_next_q   <= arg_next_n;
				local_base_q <= local_base_n;
				local_next_q <= local_next_n;
				heap_used_q  <= heap_used_n;
				heap_base_q  <= heap_base_n;
				ahc_q        <= ahc_n;
				lhc_q        <= lhc_n;
				pend_q       <= pend_n;
			end
			if (commit) stopped_q <= stop_n;
		end
	end

	// control
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_n = ST_READ;
			ST_READ: state_n = ST_EXEC;
			ST_EXEC: begin
				if (need_div && !dq_vld_q) state_n = ST_DIV;
				else if (slot_free) state_n = ST_IDLE;
			end
			ST_DIV:  if (div_rsp.done) state_n = ST_EXEC;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		commit        = 1'b0;
		div_go        = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_READ: rd_en = 1'b1;
			ST_EXEC: begin
				div_go = need_div && !dq_vld_q;
				commit = slot_free && !(need_div && !dq_vld_q);
			end
			default: ;
		endcase
	end

	assign div_req.start    = div_go;
	assign div_req.dividend = s2_q;
	assign div_req.divisor  = s1_q;

	stkm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dq_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) dq_vld_q <= 1'b0;
			else if (state_q == ST_DIV && div_rsp.done) dq_vld_q <= 1'b1;
			if (commit) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_next_q <= nxt;
			out_kind_q <= kind;
			out_pval_q <= pval;
			out_halt_q <= stop_n;
			out_err_q  <= err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_err_q, out_halt_q, out_pval_q, out_next_q};
	assign m_axis_tuser  = out_kind_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("operand stack count beyond depth");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halt state released without reset");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (func_q == F_DIV && state_q == ST_EXEC))
		else $error("divider started for a non-divide word");

	a_hist_range: assert property (@(posedge clk) disable iff (!arst_n)
		ahc_q <= HCW'(CALL_DEPTH) && lhc_q <= HCW'(CALL_DEPTH))
		else $error("frame history count beyond depth");

	a_commit_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && stopped_q) |=> (out_halt_q && out_err_q == ERR_NONE))
		else $error("halted machine produced a non-halt result");

endmodule

FILE: hdl/stkm_div.sv
// ----------------------------------------------------------------------------
// stkm_div
// signed 32-bit divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module stkm_div import stkm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitudes in, sign fixed on the way out
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			dvs_q <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
			neg_q <= req.dividend[31] ^ req.divisor[31];
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule
